/* hdl/assert_macros.svh */
// Assertion macros for the sorted timer event queue.
// Expects clk and rst in the scope of use; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, a, b)
`define ASSERT_NEXT(label, a, b)
`endif
`endif

/* hdl/steq_pkg.sv */
// Shared types and codes for the sorted timer event queue.
// No dependencies.
`default_nettype none

package steq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 32;

  localparam logic [31:0] NO_TIME = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_DISPATCH = 2'd2;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] when;
    logic [15:0] target_handle;
    logic [31:0] payload_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [1:0]  status;
    logic [15:0] handle;
    logic [31:0] event_time;
    logic [31:0] event_tag;
    logic        last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_SRCH,
    S_SHIFT,
    S_DCHK,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

/* hdl/sorted_timer_event_queue_unit.sv */
// Sorted timer event queue: schedule inserts an event in time order unless full, cancel
// removes one by handle (the head for handle 0), dispatch fires every due event in turn.
// Operations walk the entries through one slot memory port pair, one entry per cycle.
// One item at a time: input reopens once the last result enters the output register.
// Synchronous reset empties the queue and clears the handle counter.
// Depends on steq_pkg, steq_core, steq_store and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sorted_timer_event_queue_unit #(
  parameter int DEPTH    = steq_pkg::DEPTH_DEF,
  parameter int TAG_BITS = steq_pkg::TAG_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire steq_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output steq_pkg::rsp_t      rsp
);

  localparam int IW = $clog2(DEPTH);
  localparam int EW = 48 + TAG_BITS;

  logic           res_valid, res_ready;
  steq_pkg::rsp_t res;
  logic           mem_we;
  logic [IW-1:0]  mem_waddr, mem_raddr;
  logic [EW-1:0]  mem_wdata, mem_rdata;

  steq_core #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  steq_store #(
    .DEPTH (DEPTH),
    .W     (EW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

  `ASSERT_IMPLY(a_only_fired_not_last, rsp_valid && !rsp.last, rsp.reply_kind == steq_pkg::KIND_FIRED)
  `ASSERT_IMPLY(a_full_only_on_ack, rsp_valid && rsp.status == steq_pkg::ST_FULL, rsp.reply_kind == steq_pkg::KIND_ACK && rsp.handle == 16'd0)
  `ASSERT_NEXT(a_busy_after_op, req_valid && !req_stall && (req.opcode == steq_pkg::OP_SCHEDULE || req.opcode == steq_pkg::OP_CANCEL || req.opcode == steq_pkg::OP_DISPATCH), req_stall)
  `ASSERT_IMPLY(a_idle_no_result, !req_stall, !res_valid)

endmodule

`default_nettype wire

/* hdl/steq_store.sv */
// Slot memory of the event queue: one write port, one registered read port.
// No package dependencies.
`default_nettype none

module steq_store #(
  parameter int DEPTH = 16,
  parameter int W     = 80
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/steq_core.sv */
// Sequencer of the event queue: walks the slot memory one entry per cycle
// with a shared time comparator. Depends on steq_pkg.
`default_nettype none

module steq_core #(
  parameter int DEPTH    = steq_pkg::DEPTH_DEF,
  parameter int TAG_BITS = steq_pkg::TAG_BITS_DEF,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int EW = 48 + TAG_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire steq_pkg::req_t req,
  output logic               res_valid,
  input  wire logic          res_ready,
  output steq_pkg::rsp_t     res,
  output logic               mem_we,
  output logic [IW-1:0]      mem_waddr,
  output logic [EW-1:0]      mem_wdata,
  output logic [IW-1:0]      mem_raddr,
  input  wire logic [EW-1:0] mem_rdata
);

  localparam int PW = IW + 1;

  typedef struct packed {
    logic [31:0]         tm;
    logic [15:0]         hd;
    logic [TAG_BITS-1:0] tg;
  } slot_t;

  steq_pkg::state_t state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [15:0]         hc, hc_next;
  logic [IW-1:0]       idx, idx_next;
  logic [IW-1:0]       wpos, wpos_next;
  logic [31:0]         when_q, when_q_next;
  logic [15:0]         target_q, target_q_next;
  logic [TAG_BITS-1:0] tag_q, tag_q_next;
  steq_pkg::rsp_t      resp, resp_next;

  slot_t         rd;
  logic [PW-1:0] cnt_w, idx_w;
  logic          due, hit, at_end, next_is_end, full, empty;
  logic [15:0]   hc_inc, hc_new;
  logic [63:0]   tag_in_wide, tag_rd_wide;
  logic [31:0]   rd_tag32;

  assign rd          = slot_t'(mem_rdata);
  assign cnt_w       = PW'(count);
  assign idx_w       = PW'(idx);
  assign due         = rd.tm <= when_q;
  assign hit         = (target_q == 16'd0) || (rd.hd == target_q);
  assign at_end      = (idx_w + PW'(1)) == cnt_w;
  assign next_is_end = (idx_w + PW'(2)) == cnt_w;
  assign full        = cnt_w == PW'(DEPTH);
  assign empty       = count == '0;
  assign hc_inc      = hc + 16'd1;
  assign hc_new      = (hc_inc == 16'd0) ? 16'd1 : hc_inc;
  assign tag_in_wide = {32'd0, req.payload_tag};
  assign tag_rd_wide = 64'(rd.tg);
  assign rd_tag32    = tag_rd_wide[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= steq_pkg::S_IDLE;
      count <= '0;
      hc    <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      hc    <= hc_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    wpos     <= wpos_next;
    when_q   <= when_q_next;
    target_q <= target_q_next;
    tag_q    <= tag_q_next;
    resp     <= resp_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    hc_next       = hc;
    idx_next      = idx;
    wpos_next     = wpos;
    when_q_next   = when_q;
    target_q_next = target_q;
    tag_q_next    = tag_q;
    resp_next     = resp;
    case (state)
      steq_pkg::S_IDLE: begin
        if (req_valid) begin
          when_q_next   = req.when;
          target_q_next = req.target_handle;
          tag_q_next    = tag_in_wide[TAG_BITS-1:0];
          case (req.opcode)
            steq_pkg::OP_SCHEDULE: begin
              if (full) begin
                resp_next  = '{steq_pkg::KIND_ACK, steq_pkg::ST_FULL, 16'd0, 32'd0,
                               32'd0, 1'b1};
                state_next = steq_pkg::S_RESP;
              end else begin
                hc_next = hc_new;
                if (empty) begin
                  wpos_next  = '0;
                  state_next = steq_pkg::S_PUT;
                end else begin
                  idx_next   = IW'(cnt_w - PW'(1));
                  state_next = steq_pkg::S_INS;
                end
              end
            end
            steq_pkg::OP_CANCEL: begin
              if (empty) begin
                resp_next  = '{steq_pkg::KIND_CANCEL, steq_pkg::ST_NONE, 16'd0,
                               steq_pkg::NO_TIME, 32'd0, 1'b1};
                state_next = steq_pkg::S_RESP;
              end else begin
                idx_next   = '0;
                state_next = steq_pkg::S_SRCH;
              end
            end
            steq_pkg::OP_DISPATCH: begin
              idx_next   = '0;
              state_next = steq_pkg::S_DCHK;
            end
            default: begin
              state_next = steq_pkg::S_IDLE;
            end
          endcase
        end
      end
      steq_pkg::S_INS: begin
        if (due) begin
          wpos_next  = IW'(idx_w + PW'(1));
          state_next = steq_pkg::S_PUT;
        end else if (idx == '0) begin
          wpos_next  = '0;
          state_next = steq_pkg::S_PUT;
        end else begin
          idx_next = idx - IW'(1);
        end
      end
      steq_pkg::S_PUT: begin
        count_next = count + CW'(1);
        resp_next  = '{steq_pkg::KIND_ACK, steq_pkg::ST_OK, hc, when_q, 32'd0, 1'b1};
        state_next = steq_pkg::S_RESP;
      end
      steq_pkg::S_SRCH: begin
        if (hit) begin
          resp_next = '{steq_pkg::KIND_CANCEL, steq_pkg::ST_OK, rd.hd, rd.tm,
                        rd_tag32, 1'b1};
          if (at_end) begin
            count_next = count - CW'(1);
            state_next = steq_pkg::S_RESP;
          end else begin
            state_next = steq_pkg::S_SHIFT;
          end
        end else if (at_end) begin
          resp_next  = '{steq_pkg::KIND_CANCEL, steq_pkg::ST_NONE, 16'd0,
                         steq_pkg::NO_TIME, 32'd0, 1'b1};
          state_next = steq_pkg::S_RESP;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      steq_pkg::S_SHIFT: begin
        if (next_is_end) begin
          count_next = count - CW'(1);
          state_next = steq_pkg::S_RESP;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      steq_pkg::S_DCHK: begin
        if (empty) begin
          resp_next  = '{steq_pkg::KIND_END, steq_pkg::ST_NONE, 16'd0,
                         steq_pkg::NO_TIME, 32'd0, 1'b1};
          state_next = steq_pkg::S_RESP;
        end else if (due) begin
          resp_next = '{steq_pkg::KIND_FIRED, steq_pkg::ST_OK, rd.hd, rd.tm,
                        rd_tag32, 1'b0};
          if (at_end) begin
            count_next = count - CW'(1);
            state_next = steq_pkg::S_RESP;
          end else begin
            state_next = steq_pkg::S_SHIFT;
          end
        end else begin
          resp_next  = '{steq_pkg::KIND_END, steq_pkg::ST_OK, 16'd0, rd.tm, 32'd0, 1'b1};
          state_next = steq_pkg::S_RESP;
        end
      end
      steq_pkg::S_RESP: begin
        if (res_ready) begin
          if (resp.last) begin
            state_next = steq_pkg::S_IDLE;
          end else begin
            idx_next   = '0;
            state_next = steq_pkg::S_DCHK;
          end
        end
      end
      default: begin
        state_next = steq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall = state != steq_pkg::S_IDLE;
    res_valid = state == steq_pkg::S_RESP;
    res       = resp;
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    case (state)
      steq_pkg::S_IDLE: begin
        if (req.opcode == steq_pkg::OP_SCHEDULE) begin
          mem_raddr = IW'(cnt_w - PW'(1));
        end
      end
      steq_pkg::S_INS: begin
        if (!due) begin
          mem_we    = 1'b1;
          mem_waddr = IW'(idx_w + PW'(1));
          if (idx != '0) begin
            mem_raddr = idx - IW'(1);
          end
        end
      end
      steq_pkg::S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = wpos;
        mem_wdata = {when_q, hc, tag_q};
      end
      steq_pkg::S_SRCH: begin
        mem_raddr = IW'(idx_w + PW'(1));
      end
      steq_pkg::S_SHIFT: begin
        mem_we    = 1'b1;
        mem_raddr = IW'(idx_w + PW'(2));
      end
      steq_pkg::S_DCHK: begin
        mem_raddr = IW'(idx_w + PW'(1));
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sim/tb_sorted_timer_event_queue_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sorted_timer_event_queue_unit: directed steps and random
// traffic, each reply checked against a time-ordered queue predictor.
// Depends on steq_pkg and the sorted_timer_event_queue_unit RTL.

module tb_sorted_timer_event_queue_unit;

  localparam int          CLK_PERIOD     = 20;
  localparam int          QDEPTH         = steq_pkg::DEPTH_DEF;
  localparam int          RAND_PER_PHASE = 92;
  localparam int          STUCK_LIMIT    = 4000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          DRAIN_CYCLES   = 60;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;

  typedef struct {
    steq_pkg::req_t cmd;
    bit             typed;
    steq_pkg::rsp_t want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  steq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  steq_pkg::rsp_t rsp;

  logic [31:0]    slot_due [QDEPTH];
  logic [15:0]    slot_id  [QDEPTH];
  logic [31:0]    slot_tag [QDEPTH];
  int unsigned    live_cnt = 0;
  logic [15:0]    last_id = '0;
  steq_pkg::rsp_t pending_replies [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_arm = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned fail_cnt = 0;
  int unsigned stuck_cycles = 0;
  logic [31:0] now_base = 32'h0000_1000;

  sorted_timer_event_queue_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic steq_pkg::req_t mk_req(input logic [1:0] op, input logic [31:0] when,
                                            input logic [15:0] target,
                                            input logic [31:0] tag);
    steq_pkg::req_t r;
    r.opcode        = op;
    r.when          = when;
    r.target_handle = target;
    r.payload_tag   = tag;
    return r;
  endfunction

  function automatic steq_pkg::rsp_t mk_rsp(input logic [1:0] kind, input logic [1:0] status,
                                            input logic [15:0] handle,
                                            input logic [31:0] due,
                                            input logic [31:0] tag, input logic last);
    steq_pkg::rsp_t r;
    r.reply_kind = kind;
    r.status     = status;
    r.handle     = handle;
    r.event_time = due;
    r.event_tag  = tag;
    r.last       = last;
    return r;
  endfunction

  task automatic drop_slot(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < live_cnt; i++) begin
      slot_due[i] = slot_due[i + 1];
      slot_id[i]  = slot_id[i + 1];
      slot_tag[i] = slot_tag[i + 1];
    end
    live_cnt--;
  endtask

  task automatic predict_reply(input steq_pkg::req_t cmd);
    int unsigned pos;
    int unsigned fired;
    bit          hit;
    pos   = 0;
    fired = 0;
    hit   = 1'b0;
    case (cmd.opcode)
      steq_pkg::OP_SCHEDULE: begin
        if (live_cnt >= QDEPTH) begin
          pending_replies.push_back(mk_rsp(steq_pkg::KIND_ACK, steq_pkg::ST_FULL, '0, '0, '0,
                                           1'b1));
        end else begin
          last_id = last_id + 16'd1;
          if (last_id == 16'd0) last_id = 16'd1;
          while (pos < live_cnt && slot_due[pos] <= cmd.when) pos++;
          for (int unsigned i = live_cnt; i > pos; i--) begin
            slot_due[i] = slot_due[i - 1];
            slot_id[i]  = slot_id[i - 1];
            slot_tag[i] = slot_tag[i - 1];
          end
          slot_due[pos] = cmd.when;
          slot_id[pos]  = last_id;
          slot_tag[pos] = cmd.payload_tag;
          live_cnt++;
          pending_replies.push_back(mk_rsp(steq_pkg::KIND_ACK, steq_pkg::ST_OK, last_id,
                                           cmd.when, '0, 1'b1));
        end
      end
      steq_pkg::OP_CANCEL: begin
        if (cmd.target_handle == 16'd0) begin
          hit = live_cnt > 0;
        end else begin
          while (!hit && pos < live_cnt) begin
            if (slot_id[pos] == cmd.target_handle) hit = 1'b1;
            else pos++;
          end
        end
        if (!hit) begin
          pending_replies.push_back(mk_rsp(steq_pkg::KIND_CANCEL, steq_pkg::ST_NONE, '0,
                                           steq_pkg::NO_TIME, '0, 1'b1));
        end else begin
          pending_replies.push_back(mk_rsp(steq_pkg::KIND_CANCEL, steq_pkg::ST_OK,
                                           slot_id[pos], slot_due[pos], slot_tag[pos], 1'b1));
          drop_slot(pos);
        end
      end
      steq_pkg::OP_DISPATCH: begin
        while (live_cnt > 0 && slot_due[0] <= cmd.when && fired < QDEPTH) begin
          pending_replies.push_back(mk_rsp(steq_pkg::KIND_FIRED, steq_pkg::ST_OK, slot_id[0],
                                           slot_due[0], slot_tag[0], 1'b0));
          fired++;
          drop_slot(0);
        end
        if (live_cnt > 0)
          pending_replies.push_back(mk_rsp(steq_pkg::KIND_END, steq_pkg::ST_OK, '0,
                                           slot_due[0], '0, 1'b1));
        else
          pending_replies.push_back(mk_rsp(steq_pkg::KIND_END, steq_pkg::ST_NONE, '0,
                                           steq_pkg::NO_TIME, '0, 1'b1));
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_req(input steq_pkg::req_t cmd, input bit typed,
                          input steq_pkg::rsp_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= cmd;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_reply(cmd);
    if (typed) begin
      void'(pending_replies.pop_back());
      pending_replies.push_back(want);
    end
    @(negedge clk);
  endtask

  task automatic pick_random_req(output steq_pkg::req_t cmd);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    cmd  = mk_req(OP_UNUSED, $urandom, 16'($urandom), $urandom);
    if (roll < 5) begin
      cmd.opcode = OP_UNUSED;
    end else if (roll < 63) begin
      cmd.opcode = steq_pkg::OP_SCHEDULE;
      if ($urandom_range(0, 99) < 85) cmd.when = now_base + $urandom_range(0, 63);
    end else if (roll < 85) begin
      cmd.opcode = steq_pkg::OP_CANCEL;
      roll = $urandom_range(0, 99);
      if (roll < 60 && live_cnt != 0)
        cmd.target_handle = slot_id[$urandom_range(0, live_cnt - 1)];
      else if (roll < 80)
        cmd.target_handle = 16'd0;
    end else begin
      cmd.opcode = steq_pkg::OP_DISPATCH;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        cmd.when = now_base + $urandom_range(0, 40);
        now_base = now_base + $urandom_range(0, 24);
      end else if (roll < 85 && live_cnt != 0) begin
        cmd.when = slot_due[$urandom_range(0, live_cnt - 1)];
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : reply_check
    steq_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected transfer: got kind %0d status %0d handle %h time %h",
                 $time, rsp.reply_kind, rsp.status, rsp.handle, rsp.event_time);
        $display("%0t:                      tag %h last %b", $time, rsp.event_tag, rsp.last);
        fail_cnt++;
      end else begin
        want = pending_replies.pop_front();
        if (rsp !== want) begin
          $display("%0t: reply mismatch: expected kind %0d status %0d handle %h time %h",
                   $time, want.reply_kind, want.status, want.handle, want.event_time);
          $display("%0t:                 expected tag %h last %b",
                   $time, want.event_tag, want.last);
          $display("%0t:                 actual kind %0d status %0d handle %h time %h",
                   $time, rsp.reply_kind, rsp.status, rsp.handle, rsp.event_time);
          $display("%0t:                 actual tag %h last %b",
                   $time, rsp.event_tag, rsp.last);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("sorted_timer_event_queue_unit regression: fail");
      $finish;
    end
  end

  initial begin
    step_row_t      dir_steps [$];
    steq_pkg::req_t cmd;
    int unsigned    sent;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    dir_steps.push_back('{mk_req(steq_pkg::OP_CANCEL, 32'd0, 16'd0, 32'd0), 1'b1,
                          mk_rsp(steq_pkg::KIND_CANCEL, steq_pkg::ST_NONE, 16'd0,
                                 steq_pkg::NO_TIME, 32'd0, 1'b1)});
    dir_steps.push_back('{mk_req(steq_pkg::OP_DISPATCH, 32'hFFFF_FFFF, 16'd0, 32'd0), 1'b1,
                          mk_rsp(steq_pkg::KIND_END, steq_pkg::ST_NONE, 16'd0,
                                 steq_pkg::NO_TIME, 32'd0, 1'b1)});
    dir_steps.push_back('{mk_req(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, '0});
    dir_steps.push_back('{mk_req(steq_pkg::OP_SCHEDULE, 32'd0, 16'd0, 32'hFFFF_FFFF), 1'b1,
                          mk_rsp(steq_pkg::KIND_ACK, steq_pkg::ST_OK, 16'd1, 32'd0, 32'd0,
                                 1'b1)});
    dir_steps.push_back('{mk_req(steq_pkg::OP_SCHEDULE, 32'hFFFF_FFFF, 16'hFFFF, 32'd0), 1'b1,
                          mk_rsp(steq_pkg::KIND_ACK, steq_pkg::ST_OK, 16'd2, 32'hFFFF_FFFF,
                                 32'd0, 1'b1)});
    dir_steps.push_back('{mk_req(steq_pkg::OP_SCHEDULE, 32'd100, 16'd0, 32'hA5A5_A5A5), 1'b0,
                          '0});
    dir_steps.push_back('{mk_req(steq_pkg::OP_SCHEDULE, 32'd100, 16'd0, 32'h5A5A_5A5A), 1'b0,
                          '0});
    dir_steps.push_back('{mk_req(steq_pkg::OP_CANCEL, 32'd0, 16'hFFFF, 32'd0), 1'b1,
                          mk_rsp(steq_pkg::KIND_CANCEL, steq_pkg::ST_NONE, 16'd0,
                                 steq_pkg::NO_TIME, 32'd0, 1'b1)});
    dir_steps.push_back('{mk_req(steq_pkg::OP_CANCEL, 32'd0, 16'd3, 32'd0), 1'b0, '0});
    dir_steps.push_back('{mk_req(steq_pkg::OP_DISPATCH, 32'd0, 16'd0, 32'd0), 1'b0, '0});
    dir_steps.push_back('{mk_req(steq_pkg::OP_CANCEL, 32'd0, 16'd0, 32'd0), 1'b0, '0});
    for (int k = 0; k < QDEPTH - 1; k++)
      dir_steps.push_back('{mk_req(steq_pkg::OP_SCHEDULE, 32'h200 + 32'h10 * (k % 5), 16'd0,
                                   32'h0001_0000 << (k % 16) | k), 1'b0, '0});
    dir_steps.push_back('{mk_req(steq_pkg::OP_SCHEDULE, 32'd7, 16'd0, 32'h1234_5678), 1'b1,
                          mk_rsp(steq_pkg::KIND_ACK, steq_pkg::ST_FULL, 16'd0, 32'd0, 32'd0,
                                 1'b1)});
    dir_steps.push_back('{mk_req(steq_pkg::OP_DISPATCH, 32'hFFFF_FFFF, 16'd0, 32'd0), 1'b0,
                          '0});

    tx_idle_pct = 13;
    rx_idle_pct = 57;
    foreach (dir_steps[i])
      send_req(dir_steps[i].cmd, dir_steps[i].typed, dir_steps[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 13;
          rx_idle_pct = 57;
          hold_arm    = 1'b1;
        end
        1: begin
          tx_idle_pct = 57;
          rx_idle_pct = 13;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        pick_random_req(cmd);
        send_req(cmd, 1'b0, '0);
        if (cmd.opcode != OP_UNUSED) sent++;
      end
    end
    req_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("sorted_timer_event_queue_unit regression: pass");
    else
      $display("sorted_timer_event_queue_unit regression: fail");
    $finish;
  end

endmodule
